// File: hw/rtl/pcap_pkg.sv
// pcap_pkg: shared types and codes for the pulse capture block
// channel state record, sample report, history entry and result beat layout
// no dependencies
package pcap_pkg;

  localparam int TIME_W     = 40;  // width of timestamp and measured times
  localparam int ANGLE_W    = 16;
  localparam int COUNT_W    = 32;
  localparam int HIST_FILL_W = 7;  // holds a fill of up to 64 entries
  localparam int HIST_PTR_W  = 6;  // ring pointer for up to 64 entries
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // input item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  // result kinds
  localparam logic RES_REPORT = 1'b0;
  localparam logic RES_ENTRY  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 2'd1;

  typedef struct packed {
    logic                   level;
    logic                   started;
    logic                   prev_active;
    logic [TIME_W-1:0]      last_active;
    logic [TIME_W-1:0]      pulse_start;
    logic [COUNT_W-1:0]     pulses;
    logic [HIST_FILL_W-1:0] fill;
    logic [HIST_PTR_W-1:0]  head;
  } chan_state_t;

  typedef struct packed {
    logic               edge_seen;
    logic               period_valid;
    logic [TIME_W-1:0]  period_cycles;
    logic               width_valid;
    logic [TIME_W-1:0]  width_cycles;
    logic [COUNT_W-1:0] pulse_count;
  } report_t;

  typedef struct packed {
    logic [TIME_W-1:0]  time_stamp;
    logic               level;
    logic [ANGLE_W-1:0] angle;
  } hist_entry_t;

  typedef struct packed {
    logic               result_kind;
    report_t            rpt;
    logic               entry_valid;
    hist_entry_t        entry;
    logic               last;
  } result_t;

endpackage

// File: hw/rtl/pcap_state_ram.sv
// pcap_state_ram: per-channel state memory with a registered read port
// entries read as zero until first written; uses pcap_pkg
module pcap_state_ram import pcap_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int AW           = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  chan_state_t   wdata_i,
  output chan_state_t   rdata_o
);

  chan_state_t             mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  chan_state_t             rd_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// File: hw/rtl/pcap_hist_ram.sv
// pcap_hist_ram: edge history store for all channel rings
// one write and one registered read per cycle; uses pcap_pkg
module pcap_hist_ram import pcap_pkg::*; #(
  parameter int AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  hist_entry_t   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output hist_entry_t   rdata_o
);

  hist_entry_t mem_q [2**AW];
  hist_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

// File: hw/rtl/pcap_update.sv
// pcap_update: edge detection, period and width measurement, ring slot choice
// combinational read-modify step on one channel record; uses pcap_pkg
module pcap_update import pcap_pkg::*; #(
  parameter int TIME_BITS     = 40,
  parameter int HISTORY_DEPTH = 32
) (
  input  chan_state_t           st_i,
  input  logic                  level_i,
  input  logic                  act_high_i,
  input  logic [TIME_W-1:0]     now_i,
  output chan_state_t           st_o,
  output report_t               rpt_o,
  output logic                  log_we_o,
  output logic [HIST_PTR_W-1:0] log_ptr_o
);

  localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [TIME_W-1:0] TMASK = {TIME_W{1'b1}} >> (TIME_W - TW);
  localparam logic [HIST_FILL_W-1:0] HD = HIST_FILL_W'(HISTORY_DEPTH);

  logic [HIST_FILL_W-1:0] head_ext;
  logic [HIST_FILL_W-1:0] h_cur;
  logic [HIST_FILL_W-1:0] h_inc;
  logic [HIST_FILL_W-1:0] h_next;

  assign head_ext = {1'b0, st_i.head};
  assign h_cur    = (head_ext < HD) ? head_ext : '0;
  assign h_inc    = h_cur + HIST_FILL_W'(1);
  assign h_next   = (h_inc == HD) ? '0 : h_inc;

  always_comb begin
    st_o      = st_i;
    rpt_o     = '0;
    log_we_o  = 1'b0;
    log_ptr_o = '0;
    if (level_i != st_i.level) begin
      st_o.level      = level_i;
      rpt_o.edge_seen = 1'b1;
      log_we_o        = 1'b1;
      if (level_i == act_high_i) begin
        // active edge: period since previous active edge, restart pulse
        if (st_i.prev_active) begin
          rpt_o.period_valid  = 1'b1;
          rpt_o.period_cycles = (now_i - st_i.last_active) & TMASK;
        end
        st_o.last_active = now_i;
        st_o.prev_active = 1'b1;
        st_o.pulse_start = now_i;
        st_o.started     = 1'b1;
      end else if (st_i.started) begin
        rpt_o.width_valid  = 1'b1;
        rpt_o.width_cycles = (now_i - st_i.pulse_start) & TMASK;
        st_o.pulses        = st_i.pulses + COUNT_W'(1);
      end
      // ring slot: append while filling, then overwrite the oldest
      if (st_i.fill < HD) begin
        log_ptr_o = st_i.fill[HIST_PTR_W-1:0];
        st_o.fill = st_i.fill + HIST_FILL_W'(1);
      end else begin
        log_ptr_o = h_cur[HIST_PTR_W-1:0];
        st_o.head = h_next[HIST_PTR_W-1:0];
      end
    end
    rpt_o.pulse_count = st_o.pulses;
  end

endmodule

// File: hw/rtl/pulse_capture_with_edge_history.sv
// pulse_capture_with_edge_history: multi-channel input capture with edge log
// top level; uses pcap_pkg, pcap_state_ram, pcap_hist_ram, pcap_update
//
// usage
//   input channel: one beat is a pin sample (kind 0) or a history dump
//   request (kind 1) for one channel. a sample gives exactly one report
//   beat; a dump gives one history beat per logged edge, oldest first, or a
//   single empty beat when the channel is undefined or has no history.
//   the final beat of every item carries last.
//   config channel: index 0 polarity mask, index 1 channel count; always
//   ready, to be written while no item is in flight.
// timing
//   a sample: the accept edge reads the channel record from the state
//   memory; once the result register is free, the record is written back
//   and the report is loaded into the result register.
//   a dump reads the history memory one entry per cycle unless out_stall_i
//   holds the result register; each entry goes straight into that register.
//   in_stall_o is high while an item is in work; a new item is taken the
//   cycle after its last beat enters the result register.
// reset and stall
//   reset clears all channel records (written flags, no clearing pass) and
//   the channel count; polarity resets to ones; history is not cleared.
//   when out_stall_i holds the result register, the block waits and keeps
//   its read data; no beat is dropped or repeated.
module pulse_capture_with_edge_history import pcap_pkg::*; #(
  parameter int NUM_CHANNELS  = 8,
  parameter int HISTORY_DEPTH = 32,
  parameter int TIME_BITS     = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item beats
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_kind_i,
  input  logic [2:0]            in_channel_i,
  input  logic                  in_pin_level_i,
  input  logic [TIME_W-1:0]     in_timestamp_i,
  input  logic [ANGLE_W-1:0]    in_angle_i,
  // result beats
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_result_kind_o,
  output logic                  out_edge_seen_o,
  output logic                  out_period_valid_o,
  output logic [TIME_W-1:0]     out_period_cycles_o,
  output logic                  out_width_valid_o,
  output logic [TIME_W-1:0]     out_width_cycles_o,
  output logic [COUNT_W-1:0]    out_pulse_count_o,
  output logic                  out_entry_valid_o,
  output logic [TIME_W-1:0]     out_entry_time_o,
  output logic                  out_entry_level_o,
  output logic [ANGLE_W-1:0]    out_entry_angle_o,
  output logic                  out_last_o,
  // config writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HPW = $clog2(HISTORY_DEPTH);
  localparam int HAW = CHW + HPW;
  localparam int TW  = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [TIME_W-1:0] TMASK = {TIME_W{1'b1}} >> (TIME_W - TW);
  localparam logic [HIST_FILL_W-1:0] HD = HIST_FILL_W'(HISTORY_DEPTH);
  localparam logic [HPW:0] HDP = (HPW + 1)'(HISTORY_DEPTH);
  localparam logic [5:0] NC = 6'(NUM_CHANNELS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_HOUT
  } state_e;

  state_e state_q;

  // config registers
  logic [7:0] polarity_q;
  logic [3:0] chan_count_q;

  // item held while in work
  logic                  item_kind_q;
  logic [2:0]            item_ch_q;
  logic                  item_lvl_q;
  logic [TIME_W-1:0]     item_now_q;
  logic [ANGLE_W-1:0]    item_ang_q;

  // dump walk
  logic [HPW-1:0]         dump_ptr_q;
  logic [HIST_FILL_W-1:0] dump_left_q;

  // result register
  logic    out_valid_q;
  logic    out_valid_d;
  result_t out_q;
  result_t out_d;

  logic in_accept;
  logic out_free;
  logic [CHW-1:0] in_ch_idx;
  logic [CHW-1:0] item_ch_idx;
  logic [5:0] active_chans;
  logic defined;

  chan_state_t st_rd;
  chan_state_t st_new;
  report_t     rpt;
  logic                  log_we;
  logic [HIST_PTR_W-1:0] log_ptr;

  logic st_we;
  logic hist_we;
  logic hist_re;
  logic [HPW-1:0] hist_rptr;
  hist_entry_t hist_wdata;
  hist_entry_t hist_rd;

  logic [HIST_FILL_W-1:0] dump_n;
  logic [HIST_FILL_W-1:0] head_ext;
  logic [HIST_FILL_W-1:0] dump_start;
  logic dump_empty;
  logic [HPW:0] ptr_inc;
  logic [HPW-1:0] ptr_next;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign in_ch_idx   = CHW'(in_channel_i);
  assign item_ch_idx = CHW'(item_ch_q);

  // channel count above the built channels acts as the built count
  assign active_chans = ({2'b00, chan_count_q} > NC) ? NC : {2'b00, chan_count_q};
  assign defined      = ({3'b000, item_ch_q} < active_chans);

  pcap_state_ram #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AW           (CHW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (in_accept),
    .raddr_i (in_ch_idx),
    .we_i    (st_we),
    .waddr_i (item_ch_idx),
    .wdata_i (st_new),
    .rdata_o (st_rd)
  );

  pcap_update #(
    .TIME_BITS     (TIME_BITS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_update (
    .st_i       (st_rd),
    .level_i    (item_lvl_q),
    .act_high_i (polarity_q[item_ch_q]),
    .now_i      (item_now_q),
    .st_o       (st_new),
    .rpt_o      (rpt),
    .log_we_o   (log_we),
    .log_ptr_o  (log_ptr)
  );

  // write back only for a defined sample that saw an edge
  assign st_we   = (state_q == S_PROC) && out_free && (item_kind_q == KIND_SAMPLE)
                   && defined && log_we;
  assign hist_we = st_we;

  assign hist_wdata.time_stamp = item_now_q;
  assign hist_wdata.level      = item_lvl_q;
  assign hist_wdata.angle      = item_ang_q;

  // dump bounds: whole ring from the head once it has wrapped
  assign dump_n     = (st_rd.fill > HD) ? HD : st_rd.fill;
  assign head_ext   = {1'b0, st_rd.head};
  assign dump_start = (dump_n < HD) ? '0 : ((head_ext < HD) ? head_ext : '0);
  assign dump_empty = !defined || (st_rd.fill == '0);

  assign ptr_inc  = {1'b0, dump_ptr_q} + (HPW + 1)'(1);
  assign ptr_next = (ptr_inc == HDP) ? '0 : ptr_inc[HPW-1:0];

  always_comb begin
    hist_re   = 1'b0;
    hist_rptr = dump_ptr_q;
    case (state_q)
      S_PROC: begin
        if (out_free && (item_kind_q == KIND_DUMP) && !dump_empty) begin
          hist_re   = 1'b1;
          hist_rptr = dump_start[HPW-1:0];
        end
      end
      S_HOUT: begin
        if (out_free && (dump_left_q != HIST_FILL_W'(1))) begin
          hist_re   = 1'b1;
          hist_rptr = ptr_next;
        end
      end
      default: begin
        hist_re = 1'b0;
      end
    endcase
  end

  pcap_hist_ram #(
    .AW (HAW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i ({item_ch_idx, log_ptr[HPW-1:0]}),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i ({item_ch_idx, hist_rptr}),
    .rdata_o (hist_rd)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polarity_q   <= 8'hFF;
      chan_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POLARITY:   polarity_q   <= cfg_data_i;
        REG_CHAN_COUNT: chan_count_q <= cfg_data_i[3:0];
        default: begin
          polarity_q <= polarity_q;
        end
      endcase
    end
  end

  // next result beat: report, empty dump beat or history entry
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      S_PROC: begin
        if (out_free && ((item_kind_q == KIND_SAMPLE) || dump_empty)) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          if (item_kind_q == KIND_SAMPLE) begin
            out_d.result_kind = RES_REPORT;
            if (defined) begin
              out_d.rpt = rpt;
            end
          end else begin
            out_d.result_kind = RES_ENTRY;
          end
        end
      end
      S_HOUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.result_kind = RES_ENTRY;
          out_d.entry_valid = 1'b1;
          out_d.entry       = hist_rd;
          out_d.last        = (dump_left_q == HIST_FILL_W'(1));
        end
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  // sequencer, item holding and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_kind_q <= KIND_SAMPLE;
      item_ch_q   <= '0;
      item_lvl_q  <= 1'b0;
      item_now_q  <= '0;
      item_ang_q  <= '0;
      dump_ptr_q  <= '0;
      dump_left_q <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            item_kind_q <= in_kind_i;
            item_ch_q   <= in_channel_i;
            item_lvl_q  <= in_pin_level_i;
            item_now_q  <= in_timestamp_i & TMASK;
            item_ang_q  <= in_angle_i;
            state_q     <= S_PROC;
          end
        end
        S_PROC: begin
          if (out_free) begin
            if ((item_kind_q == KIND_SAMPLE) || dump_empty) begin
              state_q <= S_IDLE;
            end else begin
              // first entry read issued this cycle
              dump_ptr_q  <= dump_start[HPW-1:0];
              dump_left_q <= dump_n;
              state_q     <= S_HOUT;
            end
          end
        end
        S_HOUT: begin
          if (out_free) begin
            if (dump_left_q == HIST_FILL_W'(1)) begin
              state_q <= S_IDLE;
            end else begin
              dump_ptr_q  <= ptr_next;
              dump_left_q <= dump_left_q - HIST_FILL_W'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_result_kind_o   = out_q.result_kind;
  assign out_edge_seen_o     = out_q.rpt.edge_seen;
  assign out_period_valid_o  = out_q.rpt.period_valid;
  assign out_period_cycles_o = out_q.rpt.period_cycles;
  assign out_width_valid_o   = out_q.rpt.width_valid;
  assign out_width_cycles_o  = out_q.rpt.width_cycles;
  assign out_pulse_count_o   = out_q.rpt.pulse_count;
  assign out_entry_valid_o   = out_q.entry_valid;
  assign out_entry_time_o    = out_q.entry.time_stamp;
  assign out_entry_level_o   = out_q.entry.level;
  assign out_entry_angle_o   = out_q.entry.angle;
  assign out_last_o          = out_q.last;

  // a record enters work only from a beat accepted in the cycle before
  a_proc_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_PROC) && ($past(state_q) == S_IDLE)) |->
      $past(in_valid_i && !in_stall_o))
    else $error("record processed without an accepted item");

  // a dump walk never runs with nothing left to send
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOUT) |-> (dump_left_q != '0))
    else $error("dump walk with zero entries left");

  // ring fill never grows past the ring depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_PROC) && defined) |-> (st_rd.fill <= HD))
    else $error("history fill beyond ring depth");

endmodule
